// File: rtl/ao_blend_pkg.sv
`default_nettype none
package ao_blend_pkg;

  localparam int unsigned ChW      = 8;
  localparam int unsigned NumCh    = 3;
  localparam int unsigned WideW    = 16;
  localparam int unsigned NumW     = 24;
  localparam int unsigned DivSteps = 8;
  // products, num/den, then one quotient bit per stage
  localparam int unsigned NumStage = DivSteps + 2;
  localparam logic [ChW-1:0] ChMax = 8'd255;

  typedef struct packed {
    logic                              byp;
    logic [4*ChW-1:0]                  pix;
    logic [NumCh-1:0][ChW-1:0]         sc;
    logic [NumCh-1:0][ChW-1:0]         dc;
    logic [WideW-1:0]                  sa255;
    logic [WideW-1:0]                  dw;
    logic [WideW-1:0]                  den;
    logic [NumCh-1:0][NumW-1:0]        rem;
    logic [NumCh-1:0][ChW-1:0]         quo;
    logic [ChW-1:0]                    alpha;
  } stage_t;

endpackage
`default_nettype wire

// File: rtl/alpha_over_pixel_blend_core.sv
`default_nettype none
// channel | ports                                   | handshake
// input   | in_src_*, in_dst_* (r, g, b, alpha)     | in_valid / in_ready
// result  | out_red, out_green, out_blue, out_alpha | out_valid / out_ready
// one pixel per cycle whenever the pipe is not held
// stage 1 forms the alpha products, stage 2 numerators and denominator,
// stages 3 to 10 each settle one quotient bit of the three color divides
// the whole pipe advances together; it holds only while the last stage is full
// and out_ready is low, so nothing is dropped or repeated
// reset clears the stage valid bits only
module alpha_over_pixel_blend_core
  import ao_blend_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [ChW-1:0] in_src_red,
  input  wire logic [ChW-1:0] in_src_green,
  input  wire logic [ChW-1:0] in_src_blue,
  input  wire logic [ChW-1:0] in_src_alpha,
  input  wire logic [ChW-1:0] in_dst_red,
  input  wire logic [ChW-1:0] in_dst_green,
  input  wire logic [ChW-1:0] in_dst_blue,
  input  wire logic [ChW-1:0] in_dst_alpha,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [ChW-1:0]      out_red,
  output logic [ChW-1:0]      out_green,
  output logic [ChW-1:0]      out_blue,
  output logic [ChW-1:0]      out_alpha
);

  localparam int unsigned Last = NumStage - 1;

  logic [NumStage-1:0] v_r;
  stage_t              st_r   [NumStage];
  stage_t              st_nxt [NumStage];
  logic                adv;
  logic [WideW:0]      alpha_sum;

  assign adv      = !v_r[Last] || out_ready;
  assign in_ready = adv;

  always_comb begin
    logic [NumW-1:0] dsh;
    logic [ChW-1:0]  w;
    w = ChMax - in_src_alpha;
    dsh = '0;
    // entry: bypass decision and the two alpha products
    st_nxt[0]        = st_r[0];
    st_nxt[0].byp    = (in_src_alpha == '0) || (in_src_alpha == ChMax) || (in_dst_alpha == '0);
    st_nxt[0].pix    = (in_src_alpha == '0) ?
                       {in_dst_red, in_dst_green, in_dst_blue, in_dst_alpha} :
                       {in_src_red, in_src_green, in_src_blue, in_src_alpha};
    st_nxt[0].sc     = {in_src_red, in_src_green, in_src_blue};
    st_nxt[0].dc     = {in_dst_red, in_dst_green, in_dst_blue};
    st_nxt[0].sa255  = {in_src_alpha, 8'd0} - {8'd0, in_src_alpha};
    st_nxt[0].dw     = in_dst_alpha * w;
    // numerators and denominator
    st_nxt[1]        = st_r[0];
    st_nxt[1].den    = st_r[0].sa255 + st_r[0].dw;
    for (int c = 0; c < NumCh; c++) begin
      st_nxt[1].rem[c] = st_r[0].sc[c] * st_r[0].sa255 + st_r[0].dc[c] * st_r[0].dw;
      st_nxt[1].quo[c] = '0;
    end
    // one restoring divide step per stage, msb first
    for (int i = 1; i <= DivSteps; i++) begin
      st_nxt[i+1] = st_r[i];
      dsh = {{(NumW-WideW){1'b0}}, st_r[i].den} << (DivSteps - i);
      for (int c = 0; c < NumCh; c++) begin
        if (st_r[i].rem[c] >= dsh) begin
          st_nxt[i+1].rem[c]               = st_r[i].rem[c] - dsh;
          st_nxt[i+1].quo[c][DivSteps - i] = 1'b1;
        end
      end
    end
    // den / 255 for den below 65280
    st_nxt[2].alpha = alpha_sum[WideW-1:ChW];
  end

  assign alpha_sum = {1'b0, st_r[1].den} + 17'd1 + {9'd0, st_r[1].den[WideW-1:ChW]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[Last-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NumStage; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign out_valid = v_r[Last];
  assign out_red   = st_r[Last].byp ? st_r[Last].pix[31:24] : st_r[Last].quo[2];
  assign out_green = st_r[Last].byp ? st_r[Last].pix[23:16] : st_r[Last].quo[1];
  assign out_blue  = st_r[Last].byp ? st_r[Last].pix[15:8]  : st_r[Last].quo[0];
  assign out_alpha = st_r[Last].byp ? st_r[Last].pix[7:0]   : st_r[Last].alpha;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted request not captured");
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("pipe moved during stall");
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !st_r[Last].byp |->
      (st_r[Last].rem[0] < {8'd0, st_r[Last].den}) &&
      (st_r[Last].rem[1] < {8'd0, st_r[Last].den}) &&
      (st_r[Last].rem[2] < {8'd0, st_r[Last].den}))
    else $error("divide remainder not reduced");

endmodule
`default_nettype wire
